FILE: src/grg_pkg.sv
// ----------------------------------------------------------------------------
// grg_pkg: shared types and constants of the Givens rotation generator
// Field types of the request and response beats, flags that ride along the
// cell chains, and the fixed-point format constants.
// ----------------------------------------------------------------------------
package grg_pkg;

   // default input width (bits of a_value and b_value that are used)
   localparam int GRG_IN_WIDTH = 32;

   // fraction bits of cosine, sine and z
   localparam int FRAC_BITS = 30;
   // quotient bits of the cosine and sine division (quotient is at most 1.0)
   localparam int CS_Q_W    = FRAC_BITS + 1;
   // width of z and quotient bits of the reciprocal division
   localparam int Z_W       = 48;
   // numerator width of the reciprocal division: 2^60 plus half the divisor
   localparam int ZN_W      = 2 * FRAC_BITS + 1;

   typedef struct packed {
      logic signed [31:0] a_value;
      logic signed [31:0] b_value;
   } grg_req_type;

   typedef struct packed {
      logic signed [32:0] r_out;
      logic signed [31:0] cos_out;
      logic signed [31:0] sin_out;
      logic signed [47:0] z_out;
      logic               z_saturated;
   } grg_rsp_type;

   typedef struct packed {
      logic a_neg;
      logic b_neg;
      logic a_big;
      logic zero;
   } grg_flags_type;

   localparam int FLAGS_W = $bits(grg_flags_type);

endpackage

FILE: src/grg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// grg_sqrt_cell: one step of the digit-by-digit square root
// Resolves one root bit per cycle and hands remainder, partial root and the
// job's side data to the next cell.
// ----------------------------------------------------------------------------
module grg_sqrt_cell #(
   parameter int NW = 64,
   parameter int K  = 0,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  logic [NW-1:0] up_rem,
   input  logic [NW-1:0] up_res,
   input  logic [PW-1:0] up_pass,
   output logic          dn_valid,
   output logic [NW-1:0] dn_rem,
   output logic [NW-1:0] dn_res,
   output logic [PW-1:0] dn_pass
);
   logic          valid_ff;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] res_ff, res_in;
   logic [PW-1:0] pass_ff;
   logic [NW-1:0] trial;

   // try the next root bit, keep it when the remainder covers it
   always_comb begin
      trial = up_res + (NW'(1) << (2 * K));
      if (up_rem >= trial) begin
         rem_in = up_rem - trial;
         res_in = (up_res >> 1) + (NW'(1) << (2 * K));
      end else begin
         rem_in = up_rem;
         res_in = up_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   // advance the beat
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      pass_ff <= up_pass;
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_res   = res_ff;
   assign dn_pass  = pass_ff;

endmodule

FILE: src/grg_div_cell.sv
// ----------------------------------------------------------------------------
// grg_div_cell: one step of a restoring division
// Resolves quotient bit SHIFT for each lane against a shared divisor and
// hands the beat to the next cell.
// ----------------------------------------------------------------------------
module grg_div_cell #(
   parameter int RW    = 64,
   parameter int DW    = 32,
   parameter int QW    = 32,
   parameter int SHIFT = 0,
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   input  logic [DW-1:0]              up_den,
   input  logic [LANES-1:0][RW-1:0]   up_rem,
   input  logic [LANES-1:0][QW-1:0]   up_quo,
   input  logic [PW-1:0]              up_pass,
   output logic                       dn_valid,
   output logic [DW-1:0]              dn_den,
   output logic [LANES-1:0][RW-1:0]   dn_rem,
   output logic [LANES-1:0][QW-1:0]   dn_quo,
   output logic [PW-1:0]              dn_pass
);
   localparam int TW = DW + SHIFT;
   localparam int CW = (RW > TW) ? RW : TW;

   logic                     valid_ff;
   logic [DW-1:0]            den_ff;
   logic [LANES-1:0][RW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][QW-1:0] quo_ff, quo_in;
   logic [PW-1:0]            pass_ff;
   logic [CW-1:0]            trial;

   // subtract the shifted divisor where it fits
   always_comb begin
      trial = CW'(up_den) << SHIFT;
      for (int l = 0; l < LANES; l++) begin
         if (CW'(up_rem[l]) >= trial) begin
            rem_in[l] = up_rem[l] - trial[RW-1:0];
            quo_in[l] = up_quo[l] | (QW'(1) << SHIFT);
         end else begin
            rem_in[l] = up_rem[l];
            quo_in[l] = up_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   // advance the beat
   always_ff @(posedge clock) begin
      den_ff  <= up_den;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      pass_ff <= up_pass;
   end

   assign dn_valid = valid_ff;
   assign dn_den   = den_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;
   assign dn_pass  = pass_ff;

endmodule

FILE: src/givens_rotation_generator.sv
// ----------------------------------------------------------------------------
// givens_rotation_generator: fixed-point Givens rotation generation
// Computes signed length r, cosine, sine and reconstruction value z of a pair
// (a, b) through a square root chain and two division chains of cells.
// ----------------------------------------------------------------------------
// The block takes one (a, b) beat in every cycle and never raises busy; each
// beat yields exactly one result beat, marked by rsp_strobe for one cycle.
// Each beat passes through IN_WIDTH square root cells, 31 cells of the
// cosine/sine division and 48 cells of the reciprocal division for z,
// plus six registers for abs, squaring, sum, rounding, setup and output.
// Results cannot be held off, so the receiver must take each beat as it shows.
module givens_rotation_generator #(
   parameter int IN_WIDTH = grg_pkg::GRG_IN_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  grg_pkg::grg_req_type req_data,
   output logic                 rsp_strobe,
   output grg_pkg::grg_rsp_type rsp_data
);
   import grg_pkg::*;

   localparam int W    = IN_WIDTH;
   localparam int NW   = 2 * W;
   localparam int SPW  = FLAGS_W + 2 * W;
   localparam int CRW  = W + FRAC_BITS + 1;
   localparam int ZPW  = FLAGS_W + (W + 1) + CS_Q_W + 1;
   localparam int ZCW  = ZN_W + Z_W;

   // ---- input register: signs and magnitudes ----
   logic          s0_valid_ff;
   logic          s0_aneg_ff, s0_bneg_ff;
   logic [W-1:0]  s0_aa_ff, s0_ab_ff;
   logic [W-1:0]  a_low, b_low;

   assign busy  = 1'b0;
   assign a_low = req_data.a_value[W-1:0];
   assign b_low = req_data.b_value[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_aneg_ff <= a_low[W-1];
      s0_bneg_ff <= b_low[W-1];
      s0_aa_ff   <= a_low[W-1] ? (~a_low + W'(1)) : a_low;
      s0_ab_ff   <= b_low[W-1] ? (~b_low + W'(1)) : b_low;
   end

   // ---- squares and flags ----
   logic          s1_valid_ff;
   grg_flags_type s1_flags_ff;
   logic [W-1:0]  s1_aa_ff, s1_ab_ff;
   logic [NW-1:0] s1_sqa_ff, s1_sqb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_flags_ff.a_neg <= s0_aneg_ff;
      s1_flags_ff.b_neg <= s0_bneg_ff;
      s1_flags_ff.a_big <= s0_aa_ff > s0_ab_ff;
      s1_flags_ff.zero  <= (s0_aa_ff == '0) && (s0_ab_ff == '0);
      s1_aa_ff          <= s0_aa_ff;
      s1_ab_ff          <= s0_ab_ff;
      s1_sqa_ff         <= NW'(s0_aa_ff) * NW'(s0_aa_ff);
      s1_sqb_ff         <= NW'(s0_ab_ff) * NW'(s0_ab_ff);
   end

   // ---- sum of squares ----
   logic          s2_valid_ff;
   logic [NW-1:0] s2_n_ff;
   logic [SPW-1:0] s2_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_n_ff    <= s1_sqa_ff + s1_sqb_ff;
      s2_pass_ff <= {s1_flags_ff, s1_aa_ff, s1_ab_ff};
   end

   // ---- square root chain ----
   logic [W:0]            sq_valid;
   logic [W:0][NW-1:0]    sq_rem;
   logic [W:0][NW-1:0]    sq_res;
   logic [W:0][SPW-1:0]   sq_pass;

   assign sq_valid[0] = s2_valid_ff;
   assign sq_rem[0]   = s2_n_ff;
   assign sq_res[0]   = '0;
   assign sq_pass[0]  = s2_pass_ff;

   for (genvar j = 0; j < W; j++) begin : g_sqrt
      grg_sqrt_cell #(
         .NW (NW),
         .K  (W - 1 - j),
         .PW (SPW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sq_valid[j]),
         .up_rem   (sq_rem[j]),
         .up_res   (sq_res[j]),
         .up_pass  (sq_pass[j]),
         .dn_valid (sq_valid[j+1]),
         .dn_rem   (sq_rem[j+1]),
         .dn_res   (sq_res[j+1]),
         .dn_pass  (sq_pass[j+1])
      );
   end

   // ---- round the root to nearest ----
   logic          rd_valid_ff;
   logic [W:0]    rd_rm_ff;
   grg_flags_type rd_flags_ff;
   logic [W-1:0]  rd_aa_ff, rd_ab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= sq_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      rd_rm_ff <= sq_res[W][W:0] + (W+1)'(sq_rem[W] > sq_res[W]);
      {rd_flags_ff, rd_aa_ff, rd_ab_ff} <= sq_pass[W];
   end

   // ---- cosine and sine division chain, two lanes share the divisor ----
   logic [CS_Q_W:0]                        cs_valid;
   logic [CS_Q_W:0][W:0]                   cs_den;
   logic [CS_Q_W:0][1:0][CRW-1:0]          cs_rem;
   logic [CS_Q_W:0][1:0][CS_Q_W-1:0]       cs_quo;
   logic [CS_Q_W:0][FLAGS_W-1:0]           cs_pass;

   assign cs_valid[0]  = rd_valid_ff;
   assign cs_den[0]    = rd_rm_ff;
   assign cs_rem[0][0] = (CRW'(rd_aa_ff) << FRAC_BITS) + CRW'(rd_rm_ff >> 1);
   assign cs_rem[0][1] = (CRW'(rd_ab_ff) << FRAC_BITS) + CRW'(rd_rm_ff >> 1);
   assign cs_quo[0]    = '0;
   assign cs_pass[0]   = rd_flags_ff;

   for (genvar j = 0; j < CS_Q_W; j++) begin : g_cs
      grg_div_cell #(
         .RW    (CRW),
         .DW    (W + 1),
         .QW    (CS_Q_W),
         .SHIFT (CS_Q_W - 1 - j),
         .LANES (2),
         .PW    (FLAGS_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cs_valid[j]),
         .up_den   (cs_den[j]),
         .up_rem   (cs_rem[j]),
         .up_quo   (cs_quo[j]),
         .up_pass  (cs_pass[j]),
         .dn_valid (cs_valid[j+1]),
         .dn_den   (cs_den[j+1]),
         .dn_rem   (cs_rem[j+1]),
         .dn_quo   (cs_quo[j+1]),
         .dn_pass  (cs_pass[j+1])
      );
   end

   // ---- reciprocal setup: numerator and overflow check ----
   logic              zs_valid_ff;
   logic [CS_Q_W-1:0] zs_cm_ff;
   logic [ZN_W-1:0]   zs_num_ff;
   logic [ZPW-1:0]    zs_pass_ff;
   logic [ZN_W-1:0]   zs_num;
   logic [CS_Q_W-1:0] cs_cm;

   assign cs_cm  = cs_quo[CS_Q_W][0];
   assign zs_num = (ZN_W'(1) << (2 * FRAC_BITS)) + ZN_W'(cs_cm >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         zs_valid_ff <= 1'b0;
      end else begin
         zs_valid_ff <= cs_valid[CS_Q_W];
      end
   end

   always_ff @(posedge clock) begin
      zs_cm_ff   <= cs_cm;
      zs_num_ff  <= zs_num;
      zs_pass_ff <= {cs_pass[CS_Q_W], cs_den[CS_Q_W], cs_quo[CS_Q_W][1],
                     (ZCW'(cs_cm) << Z_W) <= ZCW'(zs_num)};
   end

   // ---- reciprocal division chain ----
   logic [Z_W:0]                   z_valid;
   logic [Z_W:0][CS_Q_W-1:0]       z_den;
   logic [Z_W:0][0:0][ZN_W-1:0]    z_rem;
   logic [Z_W:0][0:0][Z_W-1:0]     z_quo;
   logic [Z_W:0][ZPW-1:0]          z_pass;

   assign z_valid[0]  = zs_valid_ff;
   assign z_den[0]    = zs_cm_ff;
   assign z_rem[0][0] = zs_num_ff;
   assign z_quo[0]    = '0;
   assign z_pass[0]   = zs_pass_ff;

   for (genvar j = 0; j < Z_W; j++) begin : g_z
      grg_div_cell #(
         .RW    (ZN_W),
         .DW    (CS_Q_W),
         .QW    (Z_W),
         .SHIFT (Z_W - 1 - j),
         .LANES (1),
         .PW    (ZPW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (z_valid[j]),
         .up_den   (z_den[j]),
         .up_rem   (z_rem[j]),
         .up_quo   (z_quo[j]),
         .up_pass  (z_pass[j]),
         .dn_valid (z_valid[j+1]),
         .dn_den   (z_den[j+1]),
         .dn_rem   (z_rem[j+1]),
         .dn_quo   (z_quo[j+1]),
         .dn_pass  (z_pass[j+1])
      );
   end

   // ---- signs, special cases and saturation ----
   grg_flags_type     fin_flags;
   logic [W:0]        fin_rm;
   logic [CS_Q_W-1:0] fin_sm;
   logic [CS_Q_W-1:0] fin_cm;
   logic              fin_ovf;
   logic [Z_W-1:0]    fin_zq;
   logic              rneg, cneg, sneg;
   grg_rsp_type       rsp_in, rsp_ff;
   logic              strobe_ff;

   assign {fin_flags, fin_rm, fin_sm, fin_ovf} = z_pass[Z_W];
   assign fin_cm = z_den[Z_W];
   assign fin_zq = z_quo[Z_W][0];

   always_comb begin
      rneg = fin_flags.a_big ? fin_flags.a_neg : fin_flags.b_neg;
      cneg = fin_flags.a_neg ^ rneg;
      sneg = fin_flags.b_neg ^ rneg;
      rsp_in.r_out       = rneg ? -33'(fin_rm) : 33'(fin_rm);
      rsp_in.cos_out     = cneg ? -32'(fin_cm) : 32'(fin_cm);
      rsp_in.sin_out     = sneg ? -32'(fin_sm) : 32'(fin_sm);
      rsp_in.z_saturated = 1'b0;
      if (fin_flags.a_big) begin
         rsp_in.z_out = sneg ? -48'(fin_sm) : 48'(fin_sm);
      end else if (fin_cm != '0) begin
         if (cneg) begin
            if (fin_ovf || (fin_zq > (Z_W'(1) << (Z_W - 1)))) begin
               rsp_in.z_out       = Z_W'(1) << (Z_W - 1);
               rsp_in.z_saturated = 1'b1;
            end else begin
               rsp_in.z_out = -fin_zq;
            end
         end else begin
            if (fin_ovf || fin_zq[Z_W-1]) begin
               rsp_in.z_out       = ~(Z_W'(1) << (Z_W - 1));
               rsp_in.z_saturated = 1'b1;
            end else begin
               rsp_in.z_out = fin_zq;
            end
         end
      end else begin
         rsp_in.z_out = Z_W'(1) << FRAC_BITS;
      end
      // both inputs zero: identity rotation
      if (fin_flags.zero) begin
         rsp_in.r_out       = '0;
         rsp_in.cos_out     = 32'(1) << FRAC_BITS;
         rsp_in.sin_out     = '0;
         rsp_in.z_out       = '0;
         rsp_in.z_saturated = 1'b0;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= z_valid[Z_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the Givens rotation generator
// Drives (a, b) beats through a table of corner pairs and then random pairs
// with random gaps, predicts r, cosine, sine and z per beat, and compares
// every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import grg_pkg::*;

   localparam int LATENCY     = GRG_IN_WIDTH + 85;
   localparam int N_RANDOM    = 1500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_TABLE     = 22;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   grg_req_type req_data;
   logic        rsp_strobe;
   grg_rsp_type rsp_data;

   grg_rsp_type rotation_queue[$];
   int          fail_count;
   int          beats_sent;
   int          beats_checked;
   int          sat_count;
   int          cycle_count;

   // corner pairs; known results given where obvious
   typedef struct {
      logic signed [31:0] a;
      logic signed [31:0] b;
      bit                 known;
      grg_rsp_type        rsp;
   } corner_row_type;

   corner_row_type corner_table[N_TABLE];

   givens_rotation_generator uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // integer square root, rounded to nearest
   function automatic logic [63:0] isqrt_nearest(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      rem  = n;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > res) res = res + 64'd1;
      return res;
   endfunction

   // compute the rotation of one (a, b) pair
   function automatic grg_rsp_type rotation_of(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      grg_rsp_type     rsp;
      logic [63:0]     aa;
      logic [63:0]     ab;
      logic [63:0]     rm;
      logic [63:0]     cm;
      logic [63:0]     sm;
      logic [63:0]     zm;
      logic signed [63:0] c;
      logic signed [63:0] s;
      logic signed [63:0] z;
      bit              a_big;
      bit              rneg;
      aa = (a < 0) ? 64'(-64'(a)) : 64'(a);
      ab = (b < 0) ? 64'(-64'(b)) : 64'(b);
      rsp = '0;
      if (aa == 0 && ab == 0) begin
         rsp.cos_out = 32'sd1 <<< FRAC_BITS;
         return rsp;
      end
      a_big = aa > ab;
      rneg  = a_big ? (a < 0) : (b < 0);
      rm = isqrt_nearest(aa * aa + ab * ab);
      cm = ((aa << FRAC_BITS) + (rm >> 1)) / rm;
      sm = ((ab << FRAC_BITS) + (rm >> 1)) / rm;
      c  = (((a < 0) != rneg)) ? -$signed(cm) : $signed(cm);
      s  = (((b < 0) != rneg)) ? -$signed(sm) : $signed(sm);
      rsp.r_out   = rneg ? 33'(-$signed(rm)) : 33'(rm);
      rsp.cos_out = 32'(c);
      rsp.sin_out = 32'(s);
      if (a_big) begin
         z = s;
      end else if (cm != 0) begin
         zm = ((64'd1 << 60) + (cm >> 1)) / cm;
         if (c < 0) begin
            if (zm > (64'd1 << 47)) begin
               z = -(64'sd1 <<< 47);
               rsp.z_saturated = 1'b1;
            end else begin
               z = -$signed(zm);
            end
         end else begin
            if (zm > (64'd1 << 47) - 1) begin
               z = (64'sd1 <<< 47) - 1;
               rsp.z_saturated = 1'b1;
            end else begin
               z = $signed(zm);
            end
         end
      end else begin
         z = 64'sd1 <<< FRAC_BITS;
      end
      rsp.z_out = 48'(z);
      return rsp;
   endfunction

   function automatic corner_row_type corner_row(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input bit known,
                                                 input grg_rsp_type rsp);
      corner_row_type row;
      row.a     = a;
      row.b     = b;
      row.known = known;
      row.rsp   = rsp;
      return row;
   endfunction

   function automatic grg_rsp_type rsp_of(input logic signed [32:0] r,
                                          input logic signed [31:0] c,
                                          input logic signed [31:0] s,
                                          input logic signed [47:0] z);
      grg_rsp_type rsp;
      rsp.r_out       = r;
      rsp.cos_out     = c;
      rsp.sin_out     = s;
      rsp.z_out       = z;
      rsp.z_saturated = 1'b0;
      return rsp;
   endfunction

   // pick a random component, weighted toward corners and small values
   function automatic logic signed [31:0] random_component();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   // drive one beat, with a random gap before it
   task automatic send_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                            input grg_rsp_type rsp);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_data      <= '{a_value: a, b_value: b};
      rotation_queue.push_back(rsp);
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   // compare each result beat against the oldest prediction
   always @(posedge clock) begin
      grg_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rotation_queue.size() == 0) begin
            $error("result beat with no prediction waiting");
            fail_count++;
         end else begin
            want = rotation_queue.pop_front();
            beats_checked++;
            if (want.z_saturated) sat_count++;
            if (rsp_data.r_out !== want.r_out) begin
               $error("r_out: expected %0d, got %0d", want.r_out, rsp_data.r_out);
               fail_count++;
            end
            if (rsp_data.cos_out !== want.cos_out) begin
               $error("cos_out: expected %0d, got %0d", want.cos_out, rsp_data.cos_out);
               fail_count++;
            end
            if (rsp_data.sin_out !== want.sin_out) begin
               $error("sin_out: expected %0d, got %0d", want.sin_out, rsp_data.sin_out);
               fail_count++;
            end
            if (rsp_data.z_out !== want.z_out) begin
               $error("z_out: expected %0d, got %0d", want.z_out, rsp_data.z_out);
               fail_count++;
            end
            if (rsp_data.z_saturated !== want.z_saturated) begin
               $error("z_saturated: expected %0d, got %0d",
                      want.z_saturated, rsp_data.z_saturated);
               fail_count++;
            end
         end
      end
   end

   // end the run at a generous cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("givens_rotation_generator test failed");
         $finish;
      end
   end

   initial begin
      grg_rsp_type        rsp;
      logic signed [31:0] a;
      logic signed [31:0] b;
      int                 drain;
      fail_count    = 0;
      beats_sent    = 0;
      beats_checked = 0;
      sat_count     = 0;
      cycle_count   = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;

      // zero and axis pairs are known; extremes and the rest use the predictor
      corner_table[0]  = corner_row(0, 0, 1, rsp_of(0, 1 << 30, 0, 0));
      corner_table[1]  = corner_row(32'sh10000, 0, 1, rsp_of(33'sh10000, 1 << 30, 0, 0));
      corner_table[2]  = corner_row(-32'sh10000, 0, 1,
                                    rsp_of(-33'sh10000, 1 << 30, 0, 0));
      corner_table[3]  = corner_row(0, 32'sh10000, 1, rsp_of(33'sh10000, 0, 1 << 30, 1 << 30));
      corner_table[4]  = corner_row(0, -32'sh10000, 1,
                                    rsp_of(-33'sh10000, 0, 1 << 30, 1 << 30));
      corner_table[5]  = corner_row(32'sh8000_0000, 0, 0, '0);
      corner_table[6]  = corner_row(32'sh7fff_ffff, 0, 0, '0);
      corner_table[7]  = corner_row(0, 32'sh8000_0000, 0, '0);
      corner_table[8]  = corner_row(32'sh8000_0000, 32'sh8000_0000, 0, '0);
      corner_table[9]  = corner_row(32'sh7fff_ffff, 32'sh7fff_ffff, 0, '0);
      corner_table[10] = corner_row(32'sh7fff_ffff, 32'sh8000_0000, 0, '0);
      corner_table[11] = corner_row(32'sh8000_0000, 32'sh7fff_ffff, 0, '0);
      corner_table[12] = corner_row(1, 1, 0, '0);
      corner_table[13] = corner_row(-1, 1, 0, '0);
      corner_table[14] = corner_row(1, -2, 0, '0);
      // tiny a against huge b drives z into saturation
      corner_table[15] = corner_row(1, 32'sh7fff_ffff, 0, '0);
      corner_table[16] = corner_row(-1, 32'sh8000_0000, 0, '0);
      corner_table[17] = corner_row(1, 32'sh0100_0000, 0, '0);
      corner_table[18] = corner_row(32'sh0003_0000, 32'sh0004_0000, 0, '0);
      corner_table[19] = corner_row(-32'sh0004_0000, 32'sh0003_0000, 0, '0);
      corner_table[20] = corner_row(32'sh5555_5555, -32'sh2aaa_aaab, 0, '0);
      corner_table[21] = corner_row(-32'sh0000_ffff, -32'sh0000_ffff, 0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table of corner pairs
      foreach (corner_table[i]) begin
         rsp = corner_table[i].known ? corner_table[i].rsp :
               rotation_of(corner_table[i].a, corner_table[i].b);
         if (corner_table[i].known && rsp !== rotation_of(corner_table[i].a, corner_table[i].b))
            $display("note: row %0d known value differs from predictor", i);
         send_pair(corner_table[i].a, corner_table[i].b, rsp);
      end

      // random pairs, with runs of back-to-back beats
      for (int n = 0; n < N_RANDOM; n++) begin
         a = random_component();
         b = random_component();
         send_pair(a, b, rotation_of(a, b));
      end
      start <= 1'b0;

      // drain the pipeline
      drain = 0;
      while (rotation_queue.size() != 0 && drain < 4 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (rotation_queue.size() != 0) begin
         $error("%0d predicted results never arrived", rotation_queue.size());
         fail_count++;
      end

      $display("sent %0d pairs, checked %0d results, %0d with saturated z",
               beats_sent, beats_checked, sat_count);
      if (fail_count == 0) begin
         $display("givens_rotation_generator test passed");
      end else begin
         $display("givens_rotation_generator test failed");
      end
      $finish;
   end

endmodule

FILE: givens_rotation_generator.f
src/grg_pkg.sv
src/grg_sqrt_cell.sv
src/grg_div_cell.sv
src/givens_rotation_generator.sv
test/tb.sv
